// ===== rtl/core/knn_pkg.sv =====
// Package with shared types and constants of the k-nearest-neighbor selector.
package knn_pkg;
  localparam int MaxNeighbors = 16;
  localparam int MaxDimensions = 16;
  localparam int IndexBits = 16;
  localparam int CoordBits = 16;
  localparam int DistBits = 36;
  localparam int RootBits = 18;
  localparam int SlotBits = $clog2(MaxNeighbors);
  localparam int FillBits = $clog2(MaxNeighbors + 1);
  localparam int PosBits = $clog2(MaxDimensions);
  localparam int RegBits = 5;
  localparam int EntryBits = DistBits + IndexBits;

  localparam logic [1:0] CmdQuery = 2'd0;
  localparam logic [1:0] CmdCand = 2'd1;
  localparam logic [1:0] CmdEmit = 2'd2;

  localparam logic [0:0] AddrNeighborCount = 1'b0;
  localparam logic [0:0] AddrDimensions = 1'b1;

  typedef struct packed {
    logic [DistBits-1:0] distance;
    logic [IndexBits-1:0] idx;
  } entry_t;

  typedef struct packed {
    logic accumulate;
    logic load_query;
    logic clear_point;
    logic start_offer;
    logic start_emit;
  } cmd_t;

  typedef struct packed {
    logic offer_needed;
    logic busy;
  } status_t;

  function automatic logic above(entry_t a, entry_t b);
    return (a.distance > b.distance) || (a.distance == b.distance && a.idx > b.idx);
  endfunction
endpackage

// ===== rtl/core/knn_if.sv =====
// Valid/ready channel interface carrying one payload.
interface knn_if #(parameter int W = 1) (input logic clk);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/core/knn_datapath.sv =====
// Datapath: distance accumulation, heap storage, selection sort and square root.
module knn_datapath (
  input  logic clk,
  input  logic rst,
  input  knn_pkg::cmd_t cmd,
  output knn_pkg::status_t status,
  input  logic [1:0] in_cmd,
  input  logic [knn_pkg::IndexBits-1:0] in_index,
  input  logic signed [knn_pkg::CoordBits-1:0] in_coord,
  input  logic [knn_pkg::RegBits-1:0] neighbor_count,
  input  logic [knn_pkg::RegBits-1:0] dimensions,
  output logic out_valid,
  input  logic out_ready,
  output logic [knn_pkg::IndexBits-1:0] out_index,
  output logic [knn_pkg::DistBits-1:0] out_dist,
  output logic [knn_pkg::RootBits-1:0] out_root,
  output logic out_found,
  output logic out_last
);
  import knn_pkg::*;

  logic signed [CoordBits-1:0] qc [MaxDimensions];
  logic [IndexBits-1:0] query_id;
  logic [PosBits:0] pos;
  logic [DistBits-1:0] psum;
  entry_t heap [MaxNeighbors];
  logic [FillBits-1:0] fill;
  logic [FillBits-1:0] k_eff;
  logic [PosBits:0] d_eff;
  logic last_pos;
  logic signed [CoordBits:0] diff;
  logic [CoordBits:0] adiff;
  logic [2*CoordBits+1:0] sq;
  logic [DistBits:0] sum_wide;
  logic [DistBits-1:0] sum_sat;
  entry_t pend;

  // Heap insert / replace sequencer.
  typedef enum logic [2:0] {
    HIdle = 3'b001, HUp = 3'b010, HDown = 3'b100
  } hstate_t;
  hstate_t hs;
  logic [SlotBits-1:0] hi;

  // Emit sequencer: selection of the minimum, then square root.
  typedef enum logic [3:0] {
    EIdle = 4'b0001, EScan = 4'b0010, ERoot = 4'b0100, EOut = 4'b1000
  } estate_t;
  estate_t es;
  logic [FillBits-1:0] scan_i;
  logic [FillBits-1:0] remain;
  logic [MaxNeighbors-1:0] taken;
  entry_t best;
  logic [SlotBits-1:0] best_slot;
  logic best_ok;
  logic [DistBits-1:0] rv;
  logic [DistBits-1:0] root;
  logic [DistBits-1:0] rbit;
  logic [DistBits-1:0] rwork;
  logic [FillBits-1:0] total_q;
  logic out_load;
  logic [SlotBits+1:0] lc, rc;
  logic [SlotBits-1:0] top;

  always_comb begin
    k_eff = (neighbor_count == '0) ? FillBits'(1) :
            (neighbor_count > RegBits'(MaxNeighbors)) ? FillBits'(MaxNeighbors) :
            FillBits'(neighbor_count);
    d_eff = (dimensions == '0) ? (PosBits+1)'(1) :
            (dimensions > RegBits'(MaxDimensions)) ? (PosBits+1)'(MaxDimensions) :
            (PosBits+1)'(dimensions);
    last_pos = (pos + 1'b1) >= d_eff;
    diff = $signed({in_coord[CoordBits-1], in_coord}) -
           $signed({qc[pos[PosBits-1:0]][CoordBits-1], qc[pos[PosBits-1:0]]});
    adiff = diff[CoordBits] ? (CoordBits+1)'(-diff) : (CoordBits+1)'(diff);
    sq = adiff * adiff;
    sum_wide = {1'b0, psum} + (DistBits+1)'(sq);
    sum_sat = sum_wide[DistBits] ? '1 : sum_wide[DistBits-1:0];
    pend.distance = sum_sat;
    pend.idx = in_index;
  end

  assign status.offer_needed = last_pos && (in_cmd == CmdCand) && (in_index != query_id);
  assign status.busy = (hs != HIdle) || (es != EIdle);

  assign out_load = (es == EIdle && cmd.start_emit && fill == '0) ||
                    (es == ERoot && rbit == '0 && (!out_valid || out_ready));

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      qc[pos[PosBits-1:0]] <= in_coord;
    end
  end

  always_comb begin
    lc = {1'b0, hi, 1'b1};
    rc = {1'b0, hi, 1'b0} + (SlotBits+2)'(2);
    top = hi;
    if (lc < (SlotBits+2)'(fill) && above(heap[lc[SlotBits-1:0]], heap[hi]))
      top = lc[SlotBits-1:0];
    if (rc < (SlotBits+2)'(fill) && above(heap[rc[SlotBits-1:0]], heap[top]))
      top = rc[SlotBits-1:0];
  end

  always_comb begin
    rwork = rv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      query_id <= '0;
      pos <= '0;
      psum <= '0;
      fill <= '0;
      hs <= HIdle;
      es <= EIdle;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_query) begin
        query_id <= in_index;
      end
      if (cmd.accumulate || cmd.load_query) begin
        if (last_pos) begin
          pos <= '0;
          psum <= '0;
        end else begin
          pos <= pos + 1'b1;
          if (cmd.accumulate) psum <= sum_sat;
        end
      end
      if (cmd.clear_point) begin
        pos <= '0;
        psum <= '0;
      end
      if (cmd.start_offer) begin
        if (fill < k_eff) begin
          heap[fill[SlotBits-1:0]] <= pend;
          hi <= fill[SlotBits-1:0];
          fill <= fill + 1'b1;
          hs <= HUp;
        end else if (fill != '0 && above(heap[0], pend)) begin
          heap[0] <= pend;
          hi <= '0;
          hs <= HDown;
        end
      end
      unique case (hs)
        HIdle: begin
        end
        HUp: begin
          if (hi == '0) begin
            hs <= HIdle;
          end else if (above(heap[hi], heap[(hi - 1'b1) >> 1])) begin
            heap[hi] <= heap[(hi - 1'b1) >> 1];
            heap[(hi - 1'b1) >> 1] <= heap[hi];
            hi <= (hi - 1'b1) >> 1;
          end else begin
            hs <= HIdle;
          end
        end
        HDown: begin
          if (top == hi) begin
            hs <= HIdle;
          end else begin
            heap[hi] <= heap[top];
            heap[top] <= heap[hi];
            hi <= top;
          end
        end
        default: hs <= HIdle;
      endcase

      if (out_valid && out_ready && !out_load) out_valid <= 1'b0;
      unique case (es)
        EIdle: begin
          if (cmd.start_emit) begin
            pos <= '0;
            psum <= '0;
            taken <= '0;
            remain <= fill;
            fill <= '0;
            if (fill == '0) begin
              out_valid <= 1'b1;
              out_index <= '0;
              out_dist <= '0;
              out_root <= '0;
              out_found <= 1'b0;
              out_last <= 1'b1;
              es <= EOut;
            end else begin
              scan_i <= '0;
              best_ok <= 1'b0;
              es <= EScan;
            end
          end
        end
        EScan: begin
          if (scan_i == FillBits'(MaxNeighbors)) begin
            taken[best_slot] <= 1'b1;
            rv <= best.distance;
            root <= '0;
            rbit <= DistBits'(1) << (DistBits - 2);
            es <= ERoot;
          end else begin
            if (!taken[scan_i[SlotBits-1:0]] && scan_i < total_q &&
                (!best_ok || above(best, heap[scan_i[SlotBits-1:0]]))) begin
              best <= heap[scan_i[SlotBits-1:0]];
              best_slot <= scan_i[SlotBits-1:0];
              best_ok <= 1'b1;
            end
            scan_i <= scan_i + 1'b1;
          end
        end
        ERoot: begin
          if (rbit == '0) begin
            if (!out_valid || out_ready) begin
              out_valid <= 1'b1;
              out_index <= best.idx;
              out_dist <= best.distance;
              out_root <= RootBits'(root);
              out_found <= 1'b1;
              out_last <= (remain == FillBits'(1));
              remain <= remain - 1'b1;
              if (remain == FillBits'(1)) begin
                es <= EOut;
              end else begin
                scan_i <= '0;
                best_ok <= 1'b0;
                es <= EScan;
              end
            end
          end else begin
            if (rwork >= root + rbit) begin
              rv <= rwork - root - rbit;
              root <= (root >> 1) + rbit;
            end else begin
              root <= root >> 1;
            end
            rbit <= rbit >> 2;
          end
        end
        EOut: begin
          if (!out_valid || out_ready) es <= EIdle;
        end
        default: es <= EIdle;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (es == EIdle && cmd.start_emit) total_q <= fill;
  end
endmodule

// ===== rtl/core/knn_ctrl.sv =====
// Controller: accepts requests and issues commands to the datapath.
module knn_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] in_cmd,
  input  knn_pkg::status_t status,
  output knn_pkg::cmd_t cmd
);
  import knn_pkg::*;

  typedef enum logic [1:0] {Run = 2'b01, Wait = 2'b10} state_t;
  state_t state;
  logic fire;

  assign in_ready = (state == Run) && !status.busy;
  assign fire = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    if (fire) begin
      unique case (in_cmd)
        CmdQuery: cmd.load_query = 1'b1;
        CmdCand: begin
          cmd.accumulate = 1'b1;
          cmd.start_offer = status.offer_needed;
        end
        CmdEmit: cmd.start_emit = 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Run;
    end else begin
      unique case (state)
        Run: if (fire && (cmd.start_offer || cmd.start_emit)) state <= Wait;
        Wait: state <= Run;
        default: state <= Run;
      endcase
    end
  end
endmodule

// ===== rtl/core/knn_heap_select_engine.sv =====
// Top level of the k-nearest-neighbor selector with a bounded max-heap.
// Channel  Dir  Payload
// in       in   cmd, point_index, coordinate
// out      out  neighbor_index, distance_squared, distance_root, found, last_result
// apb      in   neighbor_count (0x0), dimensions (0x4)
// Coordinates are accepted while no sift or emit is busy; a finished candidate
// starts a heap sift, and an emit scans for the minimum and then takes its square
// root for each neighbor. Reset is synchronous and clears control state.
// A stalled output holds the emit sequencer.
module knn_heap_select_engine (
  input  logic clk,
  input  logic rst,
  knn_if.sink in_ch,
  knn_if.source out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import knn_pkg::*;

  logic [RegBits-1:0] neighbor_count, dimensions;
  cmd_t cmd;
  status_t status;
  logic [1:0] in_cmd;
  logic [IndexBits-1:0] in_index;
  logic signed [CoordBits-1:0] in_coord;

  assign in_cmd = in_ch.data[IndexBits+CoordBits+1:IndexBits+CoordBits];
  assign in_index = in_ch.data[IndexBits+CoordBits-1:CoordBits];
  assign in_coord = in_ch.data[CoordBits-1:0];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      neighbor_count <= RegBits'(8);
      dimensions <= RegBits'(2);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        AddrNeighborCount: neighbor_count <= pwdata[RegBits-1:0];
        AddrDimensions: dimensions <= pwdata[RegBits-1:0];
        default: begin
        end
      endcase
    end
  end

  assign prdata = paddr[2] ? 32'(dimensions) : 32'(neighbor_count);

  knn_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_cmd,
    .status, .cmd
  );

  logic [IndexBits-1:0] oi;
  logic [DistBits-1:0] od;
  logic [RootBits-1:0] orr;
  logic of, ol;

  knn_datapath u_dp (
    .clk, .rst, .cmd, .status, .in_cmd, .in_index, .in_coord,
    .neighbor_count, .dimensions,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_index(oi), .out_dist(od), .out_root(orr), .out_found(of), .out_last(ol)
  );

  assign out_ch.data = {oi, od, orr, of, ol};

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    status.busy |-> !in_ch.ready) else $error("request accepted while busy");
  a_last_found: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !of) |-> ol) else $error("empty emit not last");
endmodule
